[hw/rtl/arle_pkg.sv]
package arle_pkg;

  // Scanline framing and run-length code constants.
  localparam logic [7:0] MARKER_BYTE   = 8'h02;
  localparam logic [7:0] RUN_THRESHOLD = 8'd128;
  localparam logic [7:0] RUN_MASK      = 8'd127;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // Last channel plane of a scanline (exponent).
  localparam logic [1:0] LAST_CHANNEL = 2'd3;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_MARK1  = 3'd0,
    PH_MARK2  = 3'd1,
    PH_LENHI  = 3'd2,
    PH_LENLO  = 3'd3,
    PH_CODE   = 3'd4,
    PH_RUNVAL = 3'd5,
    PH_LIT    = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  // Segment status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MARKER  = 2'd1,
    ST_LENGTH  = 2'd2,
    ST_OVERRUN = 2'd3
  } status_t;

  // One compressed input byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       begin_image;
  } in_item_t;

  // One decoded segment.
  typedef struct packed {
    logic [15:0] row_index;
    logic [15:0] start_column;
    logic [1:0]  channel_index;
    logic [7:0]  channel_value;
    logic [6:0]  pixel_count;
    status_t     status;
    logic        image_done;
  } out_item_t;

endpackage

[hw/rtl/adaptive_rle_scanline_decoder_top.sv]
// A result is registered onto out_valid from the byte that produced it.
// One byte per cycle while in_stall is low; counters update on each accepted byte.
// A skid register holds one result while the output is stalled; in_stall rises
// only while that skid register is occupied.
// Reset (synchronous, rst_n low): decoder waits for the first marker byte, all
// counters and errors clear, image_width and image_height become 1.
module adaptive_rle_scanline_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  arle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output arle_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import arle_pkg::*;

  // Configuration registers.
  logic [15:0] width_r, height_r;

  // Decoder state.
  phase_t      phase_r, phase_nxt;
  logic [15:0] row_r, row_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [15:0] col_r, col_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  lenhi_r, lenhi_nxt;
  status_t     err_r, err_nxt;
  logic        fin_r, fin_nxt;

  // Output register and skid register.
  logic      out_valid_r, skid_valid_r;
  out_item_t out_r, skid_r;

  // State as seen by this byte, after an optional image restart.
  phase_t      eff_phase;
  logic [15:0] eff_row, eff_col;
  logic [1:0]  eff_ch;
  logic [7:0]  eff_rem, eff_lenhi;
  status_t     eff_err;
  logic        eff_fin;
  logic        blocked;

  logic        in_accept, out_take;
  logic [7:0]  b;
  logic        is_run;
  logic [7:0]  code_count;
  logic [16:0] cols_left;
  logic        overrun;
  logic [7:0]  seg_count, seg_rem;
  logic [16:0] new_col;
  logic        seg_end;
  logic [15:0] row_inc;
  logic        last_row;

  logic      res_valid;
  out_item_t res;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = in_data.data_byte;

  // Apply begin_image before the byte is decoded.
  assign eff_phase = in_data.begin_image ? PH_MARK1 : phase_r;
  assign eff_row   = in_data.begin_image ? 16'd0 : row_r;
  assign eff_col   = in_data.begin_image ? 16'd0 : col_r;
  assign eff_ch    = in_data.begin_image ? 2'd0 : ch_r;
  assign eff_rem   = in_data.begin_image ? 8'd0 : rem_r;
  assign eff_lenhi = in_data.begin_image ? 8'd0 : lenhi_r;
  assign eff_err   = in_data.begin_image ? ST_OK : err_r;
  assign eff_fin   = in_data.begin_image ? 1'b0 : fin_r;
  assign blocked   = (eff_err != ST_OK) || eff_fin;

  // Code byte decode and the check against the columns left in the plane.
  // A column beyond the width leaves a negative count, which never overruns.
  assign is_run     = b > RUN_THRESHOLD;
  assign code_count = is_run ? (b & RUN_MASK) : b;
  assign cols_left  = {1'b0, width_r} - {1'b0, eff_col};
  assign overrun    = !cols_left[16] && ({9'd0, code_count} > {1'b0, cols_left[15:0]});

  // Segment bookkeeping shared by runs and literal bytes.
  assign seg_count = (eff_phase == PH_RUNVAL) ? eff_rem : 8'd1;
  assign seg_rem   = (eff_phase == PH_RUNVAL) ? 8'd0 : eff_rem - 8'd1;
  assign new_col   = {1'b0, eff_col} + {9'd0, seg_count};
  assign seg_end   = (new_col == {1'b0, width_r}) && (seg_rem == 8'd0);
  assign row_inc   = eff_row + 16'd1;
  assign last_row  = row_inc == height_r;

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    ch_nxt    = ch_r;
    col_nxt   = col_r;
    rem_nxt   = rem_r;
    lenhi_nxt = lenhi_r;
    err_nxt   = err_r;
    fin_nxt   = fin_r;
    if (in_accept) begin
      phase_nxt = eff_phase;
      row_nxt   = eff_row;
      ch_nxt    = eff_ch;
      col_nxt   = eff_col;
      rem_nxt   = eff_rem;
      lenhi_nxt = eff_lenhi;
      err_nxt   = eff_err;
      fin_nxt   = eff_fin;
      if (!blocked) begin
        unique case (eff_phase)
          PH_MARK1: begin
            if (b != MARKER_BYTE) err_nxt = ST_MARKER;
            else phase_nxt = PH_MARK2;
          end
          PH_MARK2: begin
            if (b != MARKER_BYTE) err_nxt = ST_MARKER;
            else phase_nxt = PH_LENHI;
          end
          PH_LENHI: begin
            lenhi_nxt = b;
            phase_nxt = PH_LENLO;
          end
          PH_LENLO: begin
            if ({eff_lenhi, b} != width_r) begin
              err_nxt = ST_LENGTH;
            end else begin
              col_nxt   = 16'd0;
              ch_nxt    = 2'd0;
              phase_nxt = PH_CODE;
            end
          end
          PH_CODE: begin
            if (code_count != 8'd0) begin
              if (overrun) begin
                err_nxt = ST_OVERRUN;
              end else begin
                rem_nxt   = code_count;
                phase_nxt = is_run ? PH_RUNVAL : PH_LIT;
              end
            end
          end
          PH_RUNVAL, PH_LIT: begin
            rem_nxt = seg_rem;
            if (seg_rem == 8'd0) phase_nxt = PH_CODE;
            if (seg_end) begin
              col_nxt = 16'd0;
              if (eff_ch == LAST_CHANNEL) begin
                ch_nxt  = 2'd0;
                row_nxt = row_inc;
                if (last_row) begin
                  fin_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_MARK1;
                end
              end else begin
                ch_nxt    = eff_ch + 2'd1;
                phase_nxt = PH_CODE;
              end
            end else begin
              col_nxt = new_col[15:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result produced by the transferred byte.
  always_comb begin
    res_valid         = 1'b0;
    res.row_index     = eff_row;
    res.start_column  = eff_col;
    res.channel_index = eff_ch;
    res.channel_value = 8'd0;
    res.pixel_count   = 7'd0;
    res.status        = ST_OK;
    res.image_done    = 1'b0;
    if (in_accept && !blocked) begin
      unique case (eff_phase)
        PH_MARK1, PH_MARK2: begin
          if (b != MARKER_BYTE) begin
            res_valid  = 1'b1;
            res.status = ST_MARKER;
          end
        end
        PH_LENLO: begin
          if ({eff_lenhi, b} != width_r) begin
            res_valid  = 1'b1;
            res.status = ST_LENGTH;
          end
        end
        PH_CODE: begin
          if ((code_count != 8'd0) && overrun) begin
            res_valid  = 1'b1;
            res.status = ST_OVERRUN;
          end
        end
        PH_RUNVAL, PH_LIT: begin
          res_valid         = 1'b1;
          res.channel_value = b;
          res.pixel_count   = seg_count[6:0];
          res.image_done    = seg_end && (eff_ch == LAST_CHANNEL) && last_row;
        end
        default: ;
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARK1;
      row_r   <= 16'd0;
      ch_r    <= 2'd0;
      col_r   <= 16'd0;
      rem_r   <= 8'd0;
      lenhi_r <= 8'd0;
      err_r   <= ST_OK;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      ch_r    <= ch_nxt;
      col_r   <= col_nxt;
      rem_r   <= rem_nxt;
      lenhi_r <= lenhi_nxt;
      err_r   <= err_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  // The skid register fills only behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid while output register empty");

  // Error results cover no pixels and never end the image.
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != ST_OK) |-> (out_r.pixel_count == 7'd0) &&
      !out_r.image_done && (out_r.channel_value == 8'd0))
    else $error("error result carries pixel data");

  // A sticky error suppresses results until the image restarts.
  a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (err_r != ST_OK) |-> in_data.begin_image)
    else $error("result produced after a sticky error");

  // The finished phase is always flagged as finished.
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> fin_r)
    else $error("done phase without finished flag");

  // A completed image is followed by the finished flag.
  a_done_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.image_done |=> fin_r)
    else $error("image done without finished flag");
`endif

endmodule

[verif/rle_segment_checker.sv]
module rle_segment_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  arle_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  arle_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  mismatch_count,
  output int                  segments_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import arle_pkg::*;

  // Shadow copy of the decoder state and its two registers.
  phase_t      dec_phase;
  logic [15:0] row_pos;
  logic [15:0] col_pos;
  logic [1:0]  chan_pos;
  logic [7:0]  pixels_owed;
  logic [7:0]  length_msb;
  status_t     sticky_fault;
  logic        image_complete;
  logic [15:0] width_reg;
  logic [15:0] height_reg;

  // Segments predicted but not yet seen on the result channel.
  out_item_t expected_segments[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic void clear_decoder();
    dec_phase      = PH_MARK1;
    row_pos        = '0;
    col_pos        = '0;
    chan_pos       = '0;
    pixels_owed    = '0;
    length_msb     = '0;
    sticky_fault   = ST_OK;
    image_complete = 1'b0;
  endfunction

  // An error segment reports the current position and latches the fault.
  function automatic out_item_t flag_error(input status_t code);
    out_item_t seg;
    seg = '0;
    seg.row_index     = row_pos;
    seg.start_column  = col_pos;
    seg.channel_index = chan_pos;
    seg.status        = code;
    sticky_fault      = code;
    return seg;
  endfunction

  // Build a good segment, then step column, channel plane and scanline.
  function automatic out_item_t emit_pixels(input logic [7:0] value, input logic [6:0] count);
    out_item_t   seg;
    logic [16:0] end_col;
    seg.row_index     = row_pos;
    seg.start_column  = col_pos;
    seg.channel_index = chan_pos;
    seg.channel_value = value;
    seg.pixel_count   = count;
    seg.status        = ST_OK;
    seg.image_done    = 1'b0;
    end_col = {1'b0, col_pos} + 17'(count);
    if (end_col == {1'b0, width_reg} && pixels_owed == 8'd0) begin
      col_pos = '0;
      if (chan_pos == LAST_CHANNEL) begin
        chan_pos = '0;
        row_pos  = row_pos + 16'd1;
        if (row_pos == height_reg) begin
          image_complete = 1'b1;
          seg.image_done = 1'b1;
          dec_phase      = PH_DONE;
        end else begin
          dec_phase = PH_MARK1;
        end
      end else begin
        chan_pos  = chan_pos + 2'd1;
        dec_phase = PH_CODE;
      end
    end else begin
      col_pos = end_col[15:0];
    end
    return seg;
  endfunction

  // Advance the shadow decoder by one byte; returns 1 when a segment results.
  function automatic bit decode_byte(input in_item_t item, output out_item_t seg);
    logic [7:0]  b;
    logic [7:0]  cnt;
    logic [31:0] room;
    seg = '0;
    b = item.data_byte;
    if (item.begin_image) begin
      clear_decoder();
    end
    if (sticky_fault != ST_OK || image_complete) begin
      return 1'b0;
    end
    case (dec_phase)
      PH_MARK1: begin
        if (b != MARKER_BYTE) begin
          seg = flag_error(ST_MARKER);
          return 1'b1;
        end
        dec_phase = PH_MARK2;
      end
      PH_MARK2: begin
        if (b != MARKER_BYTE) begin
          seg = flag_error(ST_MARKER);
          return 1'b1;
        end
        dec_phase = PH_LENHI;
      end
      PH_LENHI: begin
        length_msb = b;
        dec_phase  = PH_LENLO;
      end
      PH_LENLO: begin
        if ({length_msb, b} != width_reg) begin
          seg = flag_error(ST_LENGTH);
          return 1'b1;
        end
        col_pos   = '0;
        chan_pos  = '0;
        dec_phase = PH_CODE;
      end
      PH_CODE: begin
        // The room left wraps like an unsigned 32-bit difference.
        room = {16'd0, width_reg} - {16'd0, col_pos};
        cnt  = (b > RUN_THRESHOLD) ? (b & RUN_MASK) : b;
        if (cnt != 8'd0) begin
          if ({24'd0, cnt} > room) begin
            seg = flag_error(ST_OVERRUN);
            return 1'b1;
          end
          pixels_owed = cnt;
          dec_phase   = (b > RUN_THRESHOLD) ? PH_RUNVAL : PH_LIT;
        end
      end
      PH_RUNVAL: begin
        cnt         = pixels_owed;
        pixels_owed = '0;
        dec_phase   = PH_CODE;
        seg = emit_pixels(b, cnt[6:0]);
        return 1'b1;
      end
      PH_LIT: begin
        pixels_owed = pixels_owed - 8'd1;
        if (pixels_owed == 8'd0) begin
          dec_phase = PH_CODE;
        end
        seg = emit_pixels(b, 7'd1);
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  // Compare result transfers, predict from input transfers, track register writes.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t seg;
    if (!rst_n) begin
      clear_decoder();
      width_reg      = 16'd1;
      height_reg     = 16'd1;
      mismatch_count = 0;
      expected_segments.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_segments.size() == 0) begin
          report_mismatch($sformatf("segment row %0d column %0d arrived with none expected",
                                    out_data.row_index, out_data.start_column));
        end else begin
          want = expected_segments.pop_front();
          check_field("row_index", out_data.row_index, want.row_index);
          check_field("start_column", out_data.start_column, want.start_column);
          check_field("channel_index", out_data.channel_index, want.channel_index);
          check_field("channel_value", out_data.channel_value, want.channel_value);
          check_field("pixel_count", out_data.pixel_count, want.pixel_count);
          check_field("status", out_data.status, want.status);
          check_field("image_done", out_data.image_done, want.image_done);
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data, seg)) begin
          expected_segments.push_back(seg);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: begin
          end
        endcase
      end
    end
    segments_pending <= expected_segments.size();
  end

endmodule

[verif/tb_adaptive_rle_scanline_decoder_top.sv]
module tb_adaptive_rle_scanline_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arle_pkg::*;

  typedef enum int {
    FLAW_NONE,
    FLAW_MARKER,
    FLAW_LENGTH,
    FLAW_OVERRUN,
    FLAW_TRUNCATED
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          mismatch_count;
  int          segments_pending;

  // Stimulus state.
  in_item_t    byte_q[$];
  bit          start_pending;
  bit          gaps_off;
  bit          stall_off;
  int          stall_hold = 0;
  int          random_bytes;

  always #4 clk = ~clk;

  adaptive_rle_scanline_decoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rle_segment_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .segments_pending (segments_pending)
  );

  // Backpressure on results: mostly none or short stalls, now and then a long one.
  always @(negedge clk) begin
    int pick;
    if (stall_off || !rst_n) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 6);
      end else if (pick < 95) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(8, 30);
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("Timeout: results still outstanding or input never accepted");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] non_marker();
    logic [7:0] b;
    do b = any_byte(); while (b == MARKER_BYTE);
    return b;
  endfunction

  function automatic int pick_gap();
    int p;
    if (gaps_off) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 65) begin
      return 0;
    end
    if (p < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Queue one byte; the first byte after an image start carries begin_image.
  task automatic push_byte(input logic [7:0] b);
    in_item_t item;
    item.data_byte   = b;
    item.begin_image = start_pending;
    start_pending    = 1'b0;
    byte_q.push_back(item);
  endtask

  task automatic add_header(input logic [15:0] len);
    push_byte(MARKER_BYTE);
    push_byte(MARKER_BYTE);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
  endtask

  // Cover cols pixels of one plane with random runs and literals.
  task automatic add_plane(input int cols, input bit long_runs);
    int         left;
    int         n;
    logic [7:0] code;
    left = cols;
    if (long_runs && left >= 128) begin
      // Longest literal code, then maximal runs.
      push_byte(8'h80);
      repeat (128) push_byte(any_byte());
      left = left - 128;
    end
    while (left > 0) begin
      if (long_runs) begin
        n = (left < 127) ? left : 127;
        code = n[7:0];
        push_byte(code | RUN_THRESHOLD);
        push_byte(any_byte());
      end else begin
        if ($urandom_range(0, 15) == 0) begin
          push_byte(8'h00);
        end
        n = $urandom_range(1, (left < 127) ? left : 127);
        if ($urandom_range(0, 3) == 0) begin
          n = (left < 127) ? left : 127;
        end
        code = n[7:0];
        if ($urandom_range(0, 1) == 1) begin
          push_byte(code | RUN_THRESHOLD);
          push_byte(any_byte());
        end else begin
          push_byte(code);
          repeat (n) push_byte(any_byte());
        end
      end
      left = left - n;
    end
  endtask

  // One image of the given width and row count, optionally with one flaw.
  task automatic add_image(input logic [15:0] w, input int rows, input flaw_t flaw);
    int         bad_row;
    int         bad_chan;
    int         pre;
    int         n;
    int         cut;
    logic [15:0] delta;
    logic [7:0] code;
    bad_row  = $urandom_range(0, rows - 1);
    bad_chan = $urandom_range(0, 3);
    start_pending = 1'b1;
    for (int r = 0; r < rows; r++) begin
      if (r == bad_row && flaw == FLAW_MARKER) begin
        if ($urandom_range(0, 1) == 1) begin
          push_byte(MARKER_BYTE);
        end
        push_byte(non_marker());
        return;
      end
      if (r == bad_row && flaw == FLAW_LENGTH) begin
        delta = 16'($urandom_range(1, 65535));
        add_header(w ^ delta);
        return;
      end
      add_header(w);
      for (int ch = 0; ch < 4; ch++) begin
        if (r == bad_row && flaw == FLAW_OVERRUN && ch == bad_chan) begin
          // Part of the plane, then a code longer than the columns left.
          pre = $urandom_range(0, w - 1);
          add_plane(pre, 1'b0);
          n = $urandom_range(w - pre + 1, 128);
          code = n[7:0];
          if (n < 128 && $urandom_range(0, 1) == 1) begin
            push_byte(code | RUN_THRESHOLD);
          end else begin
            push_byte(code);
          end
          return;
        end
        add_plane(w, 1'b0);
      end
    end
    if (flaw == FLAW_TRUNCATED) begin
      cut = $urandom_range(1, byte_q.size() - 1);
      while (byte_q.size() > cut) byte_q.delete(byte_q.size() - 1);
    end
  endtask

  // Drive one byte with an optional idle gap in front of it.
  task automatic send_byte(input in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_queued();
    while (byte_q.size() > 0) send_byte(byte_q.pop_front());
    @(negedge clk) in_valid <= 1'b0;
  endtask

  // Wait for every predicted segment, plus the pipeline latency.
  task automatic drain_results();
    wait (segments_pending == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  initial begin
    int         p;
    logic [15:0] w;
    logic [15:0] h;
    int         rows;
    flaw_t      flaw;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_IMAGE_WIDTH;
    cfg_data   = '0;
    gaps_off   = 1'b0;
    stall_off  = 1'b0;
    random_bytes  = 0;
    start_pending = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a 1x1 image with a zero code, literals and runs, then ignored bytes.
    start_pending = 1'b1;
    add_header(16'd1);
    push_byte(8'h00);
    push_byte(8'h01); push_byte(8'hFF);
    push_byte(8'h81); push_byte(8'h00);
    push_byte(8'h01); push_byte(8'hAA);
    push_byte(8'h81); push_byte(8'h55);
    push_byte(8'hFF);
    // Bad first marker byte; the next byte is ignored.
    start_pending = 1'b1;
    push_byte(8'h03); push_byte(MARKER_BYTE);
    // Bad second marker byte.
    start_pending = 1'b1;
    push_byte(MARKER_BYTE); push_byte(8'h00);
    // Length that differs from the width.
    start_pending = 1'b1;
    add_header(16'd2);
    // Literal code of 128 runs past the scanline end.
    start_pending = 1'b1;
    add_header(16'd1);
    push_byte(8'h80);
    send_queued();

    // Width zero: the length is accepted and any nonzero code overruns.
    drain_results();
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    start_pending = 1'b1;
    add_header(16'd0);
    push_byte(8'h00);
    push_byte(8'h85);
    send_queued();

    // Widest scanline length, opened with the longest literal code and maximal runs.
    drain_results();
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    start_pending = 1'b1;
    add_header(16'hFFFF);
    add_plane(300, 1'b1);
    send_queued();

    // Random images over a series of geometry settings.
    while (random_bytes < 520) begin
      p = $urandom_range(0, 99);
      if (p < 10) begin
        w = 16'd1;
      end else if (p < 20) begin
        w = 16'($urandom_range(64, 127));
      end else begin
        w = 16'($urandom_range(2, 40));
      end
      p = $urandom_range(0, 99);
      if (p < 5) begin
        h = 16'd0;
      end else if (p < 10) begin
        h = 16'hFFFF;
      end else if (w >= 64) begin
        h = 16'd1;
      end else begin
        h = 16'($urandom_range(1, 3));
      end
      // Heights that never complete get a couple of rows only.
      rows = (h == 16'd0 || h == 16'hFFFF) ? 2 : int'(h);

      drain_results();
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
      gaps_off  = ($urandom_range(0, 5) == 0);
      stall_off = ($urandom_range(0, 5) == 0);

      repeat ($urandom_range(2, 4)) begin
        if (random_bytes >= 520) break;
        p = $urandom_range(0, 99);
        if (p < 70) begin
          flaw = FLAW_NONE;
        end else if (p < 76) begin
          flaw = FLAW_MARKER;
        end else if (p < 82) begin
          flaw = FLAW_LENGTH;
        end else if (p < 91) begin
          flaw = FLAW_OVERRUN;
        end else begin
          flaw = FLAW_TRUNCATED;
        end
        add_image(w, rows, flaw);
        random_bytes = random_bytes + byte_q.size();
        // Trailing bytes after an error or a finished image are ignored.
        if (flaw == FLAW_MARKER || flaw == FLAW_LENGTH || flaw == FLAW_OVERRUN ||
            (flaw == FLAW_NONE && rows == int'(h))) begin
          repeat ($urandom_range(0, 3)) push_byte(any_byte());
        end
        send_queued();
        if ($urandom_range(0, 7) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
